FILE: rtl/epsv_pkg.sv
// Shared constants and types for the ellipsoid point splat volume.
package epsv_pkg;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned POS_W = 16;
	localparam int unsigned RAD_W = 3;
	localparam int unsigned IDX_W = 15;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned OUT_CNT_W = 16;
	localparam int unsigned HIT_W = 12;

	localparam logic [KIND_W-1:0] KIND_SPLAT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_RADIUS_X = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_RADIUS_Y = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_RADIUS_Z = 3'd5;

	typedef struct packed {
		logic signed [POS_W-1:0] origin_x;
		logic signed [POS_W-1:0] origin_y;
		logic signed [POS_W-1:0] origin_z;
		logic [RAD_W-1:0] radius_x;
		logic [RAD_W-1:0] radius_y;
		logic [RAD_W-1:0] radius_z;
	} cfg_t;

	typedef struct packed {
		logic hit;
		logic done;
	} walk_t;

	typedef struct packed {
		logic splat_start;
		logic rd_go;
		logic clr_go;
	} vol_cmd_t;

endpackage

FILE: rtl/epsv_if.sv
// Request and response channel interfaces.
interface epsv_req_if import epsv_pkg::*; ();
	logic valid;
	logic ready;
	logic [KIND_W-1:0] kind;
	logic signed [POS_W-1:0] point_x;
	logic signed [POS_W-1:0] point_y;
	logic signed [POS_W-1:0] point_z;
	logic [IDX_W-1:0] voxel_index;

	modport source (output valid, kind, point_x, point_y, point_z, voxel_index, input ready);
	modport sink (input valid, kind, point_x, point_y, point_z, voxel_index, output ready);
endinterface

interface epsv_rsp_if import epsv_pkg::*; ();
	logic valid;
	logic ready;
	logic [OUT_CNT_W-1:0] voxel_count;
	logic [OUT_CNT_W-1:0] max_count;
	logic [HIT_W-1:0] voxels_hit;

	modport source (output valid, voxel_count, max_count, voxels_hit, input ready);
	modport sink (input valid, voxel_count, max_count, voxels_hit, output ready);
endinterface

FILE: rtl/epsv_cfg.sv
// APB configuration registers: window origin and ellipsoid radii.
module epsv_cfg import epsv_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready,
	output cfg_t cfg
);
	cfg_t cfg_q;
	logic wr;
	logic [REG_IDX_W-1:0] reg_idx;

	assign wr = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
			cfg_q.origin_z <= '0;
			cfg_q.radius_x <= RAD_W'(1);
			cfg_q.radius_y <= RAD_W'(1);
			cfg_q.radius_z <= RAD_W'(1);
		end else if (wr) begin
			case (reg_idx)
				REG_ORIGIN_X: cfg_q.origin_x <= pwdata[POS_W-1:0];
				REG_ORIGIN_Y: cfg_q.origin_y <= pwdata[POS_W-1:0];
				REG_ORIGIN_Z: cfg_q.origin_z <= pwdata[POS_W-1:0];
				REG_RADIUS_X: cfg_q.radius_x <= pwdata[RAD_W-1:0];
				REG_RADIUS_Y: cfg_q.radius_y <= pwdata[RAD_W-1:0];
				REG_RADIUS_Z: cfg_q.radius_z <= pwdata[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ORIGIN_X: prdata = DATA_W'(cfg_q.origin_x);
			REG_ORIGIN_Y: prdata = DATA_W'(cfg_q.origin_y);
			REG_ORIGIN_Z: prdata = DATA_W'(cfg_q.origin_z);
			REG_RADIUS_X: prdata = DATA_W'(cfg_q.radius_x);
			REG_RADIUS_Y: prdata = DATA_W'(cfg_q.radius_y);
			REG_RADIUS_Z: prdata = DATA_W'(cfg_q.radius_z);
			default: prdata = '0;
		endcase
	end

endmodule

FILE: rtl/epsv_geom.sv
// Splat sequencer: shared-multiplier setup, then one ellipsoid offset per cycle.
module epsv_geom import epsv_pkg::*; #(
	parameter int VOL_W = 32,
	parameter int VOL_H = 32,
	parameter int VOL_D = 32,
	parameter int MAX_RADIUS = 7,
	parameter int AW = 15
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input cfg_t cfg,
	input logic signed [POS_W-1:0] px,
	input logic signed [POS_W-1:0] py,
	input logic signed [POS_W-1:0] pz,
	output walk_t walk,
	output logic [AW-1:0] addr
);
	localparam int RW = (MAX_RADIUS < 1) ? 1 : $clog2(MAX_RADIUS + 1);
	localparam int KW = RW + 1;
	localparam int SQW = 2 * RW;
	localparam int WW = 4 * RW;
	localparam int PW = 6 * RW;
	localparam int TW = PW + 3;
	localparam int OW = POS_W + 2;
	localparam int MAW = (WW > AW) ? WW : AW;
	localparam int MBW = (SQW > AW) ? SQW : AW;
	localparam int PRW = MAW + MBW;
	localparam int PLANE = VOL_W * VOL_H;

	typedef enum logic [14:0] {
		G_IDLE = 15'b000000000000001,
		G_SQX  = 15'b000000000000010,
		G_SQY  = 15'b000000000000100,
		G_SQZ  = 15'b000000000001000,
		G_SXY  = 15'b000000000010000,
		G_WX   = 15'b000000000100000,
		G_WY   = 15'b000000001000000,
		G_PROD = 15'b000000010000000,
		G_UX   = 15'b000000100000000,
		G_UY   = 15'b000001000000000,
		G_UZ   = 15'b000010000000000,
		G_YB   = 15'b000100000000000,
		G_ZB   = 15'b001000000000000,
		G_INIT = 15'b010000000000000,
		G_WALK = 15'b100000000000000
	} gstate_t;

	function automatic logic [RW-1:0] clamp_r(input logic [RAD_W-1:0] r);
		logic [RW-1:0] c;
		if (int'(r) > MAX_RADIUS) c = RW'(MAX_RADIUS);
		else c = RW'(r);
		return c;
	endfunction

	function automatic logic [KW-1:0] odd_r(input logic [RW-1:0] r);
		logic [KW-1:0] o;
		if (r == '0) o = '0;
		else o = {r, 1'b0} - KW'(1);
		return o;
	endfunction

	gstate_t state_q, state_d;

	logic [RW-1:0] rx, ry, rz;
	logic signed [OW-1:0] xo0, yo0, zo0;
	logic [MAW-1:0] mul_a;
	logic [MBW-1:0] mul_b;
	logic [PRW-1:0] mul_p;

	logic [SQW-1:0] sx_q, sy_q, sz_q, sxp, syp, szp;
	logic [WW-1:0] sxy_q, wx_q, wy_q, wz_q;
	logic [PW-1:0] prod_q;
	logic [TW-1:0] ux0_q, uy0_q, uz0_q;
	logic [AW-1:0] ybase_q, zbase_q;

	logic [TW-1:0] tx_q, ty_q, tz_q, ux_q, uy_q, uz_q;
	logic [TW-1:0] tx0, ty0, tz0, ell_sum;
	logic signed [OW-1:0] xo_q, yo_q, zo_q;
	logic [KW-1:0] kx_q, ky_q, kz_q;
	logic [AW-1:0] idx_q, row_q, plane_q;
	logic last_x, last_y, last_z, in_ell, in_win;

	assign rx = clamp_r(cfg.radius_x);
	assign ry = clamp_r(cfg.radius_y);
	assign rz = clamp_r(cfg.radius_z);

	// first offset of the walk, relative to the window origin
	assign xo0 = OW'(px) - OW'(cfg.origin_x) - OW'({1'b0, rx});
	assign yo0 = OW'(py) - OW'(cfg.origin_y) - OW'({1'b0, ry});
	assign zo0 = OW'(pz) - OW'(cfg.origin_z) - OW'({1'b0, rz});

	assign sxp = (sx_q == '0) ? SQW'(1) : sx_q;
	assign syp = (sy_q == '0) ? SQW'(1) : sy_q;
	assign szp = (sz_q == '0) ? SQW'(1) : sz_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			G_SQX: begin mul_a = MAW'(rx); mul_b = MBW'(rx); end
			G_SQY: begin mul_a = MAW'(ry); mul_b = MBW'(ry); end
			G_SQZ: begin mul_a = MAW'(rz); mul_b = MBW'(rz); end
			G_SXY: begin mul_a = MAW'(sxp); mul_b = MBW'(syp); end
			G_WX: begin mul_a = MAW'(syp); mul_b = MBW'(szp); end
			G_WY: begin mul_a = MAW'(sxp); mul_b = MBW'(szp); end
			G_PROD: begin mul_a = MAW'(sxy_q); mul_b = MBW'(szp); end
			G_UX: begin mul_a = MAW'(wx_q); mul_b = MBW'(odd_r(rx)); end
			G_UY: begin mul_a = MAW'(wy_q); mul_b = MBW'(odd_r(ry)); end
			G_UZ: begin mul_a = MAW'(wz_q); mul_b = MBW'(odd_r(rz)); end
			G_YB: begin mul_a = MAW'(AW'(yo0)); mul_b = MBW'(AW'(VOL_W)); end
			G_ZB: begin mul_a = MAW'(AW'(zo0)); mul_b = MBW'(AW'(PLANE)); end
			default: ;
		endcase
	end

	assign mul_p = PRW'(mul_a) * PRW'(mul_b);

	// squared-distance terms at offset -r: r^2 * w equals the full product
	assign tx0 = (sx_q == '0) ? '0 : TW'(prod_q);
	assign ty0 = (sy_q == '0) ? '0 : TW'(prod_q);
	assign tz0 = (sz_q == '0) ? '0 : TW'(prod_q);

	assign ell_sum = tx_q + ty_q + tz_q;
	assign in_ell = ell_sum <= TW'(prod_q);
	assign in_win = !xo_q[OW-1] && (xo_q[OW-2:0] < (OW-1)'(VOL_W))
		&& !yo_q[OW-1] && (yo_q[OW-2:0] < (OW-1)'(VOL_H))
		&& !zo_q[OW-1] && (zo_q[OW-2:0] < (OW-1)'(VOL_D));

	assign last_x = kx_q == {rx, 1'b0};
	assign last_y = ky_q == {ry, 1'b0};
	assign last_z = kz_q == {rz, 1'b0};

	assign walk.hit = (state_q == G_WALK) && in_ell && in_win;
	assign walk.done = (state_q == G_WALK) && last_x && last_y && last_z;
	assign addr = idx_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			G_IDLE: if (start) state_d = G_SQX;
			G_SQX: state_d = G_SQY;
			G_SQY: state_d = G_SQZ;
			G_SQZ: state_d = G_SXY;
			G_SXY: state_d = G_WX;
			G_WX: state_d = G_WY;
			G_WY: state_d = G_PROD;
			G_PROD: state_d = G_UX;
			G_UX: state_d = G_UY;
			G_UY: state_d = G_UZ;
			G_UZ: state_d = G_YB;
			G_YB: state_d = G_ZB;
			G_ZB: state_d = G_INIT;
			G_INIT: state_d = G_WALK;
			G_WALK: if (walk.done) state_d = G_IDLE;
			default: state_d = G_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			G_SQX: sx_q <= SQW'(mul_p);
			G_SQY: sy_q <= SQW'(mul_p);
			G_SQZ: sz_q <= SQW'(mul_p);
			G_SXY: sxy_q <= WW'(mul_p);
			G_WX: wx_q <= (sx_q == '0) ? '0 : WW'(mul_p);
			G_WY: wy_q <= (sy_q == '0) ? '0 : WW'(mul_p);
			G_PROD: begin
				prod_q <= PW'(mul_p);
				wz_q <= (sz_q == '0) ? '0 : sxy_q;
			end
			G_UX: ux0_q <= TW'(0) - TW'(mul_p);
			G_UY: uy0_q <= TW'(0) - TW'(mul_p);
			G_UZ: uz0_q <= TW'(0) - TW'(mul_p);
			G_YB: ybase_q <= AW'(mul_p);
			G_ZB: zbase_q <= AW'(mul_p);
			G_INIT: begin
				tx_q <= tx0;
				ty_q <= ty0;
				tz_q <= tz0;
				ux_q <= ux0_q;
				uy_q <= uy0_q;
				uz_q <= uz0_q;
				xo_q <= xo0;
				yo_q <= yo0;
				zo_q <= zo0;
				kx_q <= '0;
				ky_q <= '0;
				kz_q <= '0;
				idx_q <= zbase_q + ybase_q + AW'(xo0);
				row_q <= zbase_q + ybase_q + AW'(xo0);
				plane_q <= zbase_q + ybase_q + AW'(xo0);
			end
			G_WALK: begin
				// advance the term by its running difference, and that by twice the weight
				if (!last_x) begin
					kx_q <= kx_q + KW'(1);
					xo_q <= xo_q + OW'(1);
					idx_q <= idx_q + AW'(1);
					tx_q <= tx_q + ux_q;
					ux_q <= ux_q + TW'({wx_q, 1'b0});
				end else begin
					kx_q <= '0;
					xo_q <= xo0;
					tx_q <= tx0;
					ux_q <= ux0_q;
					if (!last_y) begin
						ky_q <= ky_q + KW'(1);
						yo_q <= yo_q + OW'(1);
						ty_q <= ty_q + uy_q;
						uy_q <= uy_q + TW'({wy_q, 1'b0});
						row_q <= row_q + AW'(VOL_W);
						idx_q <= row_q + AW'(VOL_W);
					end else begin
						ky_q <= '0;
						yo_q <= yo0;
						ty_q <= ty0;
						uy_q <= uy0_q;
						kz_q <= kz_q + KW'(1);
						zo_q <= zo_q + OW'(1);
						tz_q <= tz_q + uz_q;
						uz_q <= uz_q + TW'({wz_q, 1'b0});
						plane_q <= plane_q + AW'(PLANE);
						row_q <= plane_q + AW'(PLANE);
						idx_q <= plane_q + AW'(PLANE);
					end
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/epsv_vol.sv
// Voxel count memory with read-modify-write, clearing sweep and peak tracking.
module epsv_vol import epsv_pkg::*; #(
	parameter int VOXELS = 32768,
	parameter int COUNT_BITS = 16,
	parameter int AW = 15
) (
	input logic clk,
	input logic arst_n,
	input vol_cmd_t cmd,
	input walk_t walk,
	input logic [AW-1:0] walk_addr,
	input logic [AW-1:0] rd_addr,
	output logic clr_busy,
	output logic [COUNT_BITS-1:0] rd_data,
	output logic [COUNT_BITS-1:0] peak,
	output logic [HIT_W-1:0] hits
);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [COUNT_BITS-1:0] mem [VOXELS];
	logic [COUNT_BITS-1:0] rdata_q, inc, peak_q;
	logic [AW-1:0] clr_addr_q, upd_addr_s1, rd_sel;
	logic [HIT_W-1:0] hits_q;
	logic clr_q, upd_s1, rd_en;

	assign rd_en = walk.hit || cmd.rd_go;
	assign rd_sel = walk.hit ? walk_addr : rd_addr;
	assign inc = (rdata_q == CNT_MAX) ? rdata_q : rdata_q + COUNT_BITS'(1);

	assign clr_busy = clr_q;
	assign rd_data = rdata_q;
	assign peak = peak_q;
	assign hits = hits_q;

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= '0;
		end else if (upd_s1) begin
			mem[upd_addr_s1] <= inc;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_sel];
		end
		upd_addr_s1 <= walk_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_addr_q <= '0;
			upd_s1 <= 1'b0;
			peak_q <= '0;
			hits_q <= '0;
		end else begin
			upd_s1 <= walk.hit;
			if (cmd.clr_go) begin
				clr_q <= 1'b1;
				clr_addr_q <= '0;
				peak_q <= '0;
			end else if (clr_q) begin
				if (clr_addr_q == AW'(VOXELS - 1)) clr_q <= 1'b0;
				clr_addr_q <= clr_addr_q + AW'(1);
			end else if (upd_s1 && (inc > peak_q)) begin
				peak_q <= inc;
			end
			// hold the hit count at its ceiling
			if (cmd.splat_start) begin
				hits_q <= '0;
			end else if (upd_s1 && (hits_q != '1)) begin
				hits_q <= hits_q + HIT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/ellipsoid_point_splat_volume.sv
// Splat: N = (2rx+1)(2ry+1)(2rz+1) offsets are walked after 12 setup steps on the
// shared multiplier and a load step, with at most one voxel read-modify-write
// per cycle.
// Read: one memory read. Clear: one memory entry per cycle over all VOL_W*VOL_H*VOL_D entries.
// One request at a time; the next is taken once the block is idle again.
// After reset a clearing pass over all VOL_W*VOL_H*VOL_D entries (32768 by default) runs
// before the first request; configuration registers are writable throughout.
module ellipsoid_point_splat_volume import epsv_pkg::*; #(
	parameter int VOL_W = 32,
	parameter int VOL_H = 32,
	parameter int VOL_D = 32,
	parameter int MAX_RADIUS = 7,
	parameter int COUNT_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready,
	epsv_req_if.sink req,
	epsv_rsp_if.source rsp
);
	localparam int VOXELS = VOL_W * VOL_H * VOL_D;
	localparam int AW = (VOXELS < 2) ? 1 : $clog2(VOXELS);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b00000001,
		S_SPLAT  = 8'b00000010,
		S_WALK   = 8'b00000100,
		S_DRAIN  = 8'b00001000,
		S_READ   = 8'b00010000,
		S_CLEAR  = 8'b00100000,
		S_CLRW   = 8'b01000000,
		S_FINISH = 8'b10000000
	} state_t;

	state_t state_q, state_d;
	cfg_t cfg;
	walk_t walk;
	vol_cmd_t cmd;

	logic [KIND_W-1:0] kind_q;
	logic signed [POS_W-1:0] px_q, py_q, pz_q;
	logic [IDX_W-1:0] vidx_q;
	logic [AW-1:0] walk_addr;
	logic clr_busy, accept, in_range, out_free, valid_q;
	logic [COUNT_BITS-1:0] rd_data, peak;
	logic [HIT_W-1:0] hits;
	logic [OUT_CNT_W-1:0] count_q, max_q;
	logic [HIT_W-1:0] hit_q;

	epsv_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	epsv_geom #(
		.VOL_W(VOL_W),
		.VOL_H(VOL_H),
		.VOL_D(VOL_D),
		.MAX_RADIUS(MAX_RADIUS),
		.AW(AW)
	) u_geom (
		.clk(clk),
		.arst_n(arst_n),
		.start(state_q == S_SPLAT),
		.cfg(cfg),
		.px(px_q),
		.py(py_q),
		.pz(pz_q),
		.walk(walk),
		.addr(walk_addr)
	);

	epsv_vol #(
		.VOXELS(VOXELS),
		.COUNT_BITS(COUNT_BITS),
		.AW(AW)
	) u_vol (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.walk(walk),
		.walk_addr(walk_addr),
		.rd_addr(AW'(vidx_q)),
		.clr_busy(clr_busy),
		.rd_data(rd_data),
		.peak(peak),
		.hits(hits)
	);

	assign req.ready = (state_q == S_IDLE) && !clr_busy;
	assign accept = req.valid && req.ready;
	assign in_range = 32'(vidx_q) < VOXELS;
	assign out_free = !valid_q || rsp.ready;

	assign cmd.splat_start = state_q == S_SPLAT;
	assign cmd.rd_go = (state_q == S_READ) && in_range;
	assign cmd.clr_go = state_q == S_CLEAR;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.kind)
						KIND_SPLAT: state_d = S_SPLAT;
						KIND_READ: state_d = S_READ;
						KIND_CLEAR: state_d = S_CLEAR;
						default: state_d = S_FINISH;
					endcase
				end
			end
			S_SPLAT: state_d = S_WALK;
			S_WALK: if (walk.done) state_d = S_DRAIN;
			// let the last read-modify-write land before reporting
			S_DRAIN: state_d = S_FINISH;
			S_READ: state_d = S_FINISH;
			S_CLEAR: state_d = S_CLRW;
			S_CLRW: if (!clr_busy) state_d = S_FINISH;
			S_FINISH: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == S_FINISH) && out_free) begin
				valid_q <= 1'b1;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= req.kind;
			px_q <= req.point_x;
			py_q <= req.point_y;
			pz_q <= req.point_z;
			vidx_q <= req.voxel_index;
		end
		if ((state_q == S_FINISH) && out_free) begin
			count_q <= ((kind_q == KIND_READ) && in_range) ? OUT_CNT_W'(rd_data) : '0;
			max_q <= OUT_CNT_W'(peak);
			hit_q <= (kind_q == KIND_SPLAT) ? hits : '0;
		end
	end

	assign rsp.valid = valid_q;
	assign rsp.voxel_count = count_q;
	assign rsp.max_count = max_q;
	assign rsp.voxels_hit = hit_q;

endmodule

FILE: verif/ellipsoid_point_splat_volume_tb.sv
// Self-checking testbench for the ellipsoid point splat volume: predicts every response.
module ellipsoid_point_splat_volume_tb;
	import epsv_pkg::*;

	localparam int VOL_W = 32;
	localparam int VOL_H = 32;
	localparam int VOL_D = 32;
	localparam int MAX_RADIUS = 7;
	localparam int COUNT_BITS = 16;
	localparam int VOXELS = VOL_W * VOL_H * VOL_D;
	localparam int COORD_W = 5;
	localparam int HIT_CAP = 4095;
	localparam int CYCLE_LIMIT = 3000000;
	localparam logic [COUNT_BITS-1:0] COUNT_CAP = '1;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic signed [POS_W-1:0] point_x;
		logic signed [POS_W-1:0] point_y;
		logic signed [POS_W-1:0] point_z;
		logic [IDX_W-1:0] voxel_index;
	} splat_req_t;

	typedef struct packed {
		logic [OUT_CNT_W-1:0] voxel_count;
		logic [OUT_CNT_W-1:0] max_count;
		logic [HIT_W-1:0] voxels_hit;
	} splat_rsp_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	epsv_req_if req_if();
	epsv_rsp_if rsp_if();

	ellipsoid_point_splat_volume #(
		.VOL_W(VOL_W),
		.VOL_H(VOL_H),
		.VOL_D(VOL_D),
		.MAX_RADIUS(MAX_RADIUS),
		.COUNT_BITS(COUNT_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req(req_if),
		.rsp(rsp_if)
	);

	always #5 clk = ~clk;

	// Window and ellipsoid settings as last written.
	logic signed [POS_W-1:0] win_x = '0;
	logic signed [POS_W-1:0] win_y = '0;
	logic signed [POS_W-1:0] win_z = '0;
	logic [RAD_W-1:0] rad_x = 3'd1;
	logic [RAD_W-1:0] rad_y = 3'd1;
	logic [RAD_W-1:0] rad_z = 3'd1;

	logic [COUNT_BITS-1:0] voxel_counts [VOXELS];
	logic [COUNT_BITS-1:0] peak_level = '0;

	splat_req_t queued_requests[$];
	splat_rsp_t awaited_responses[$];
	splat_req_t cur_req;

	int gap_left = 0;
	int stall_left = 0;
	bit calm = 1'b0;
	int cycle_count = 0;
	int fail_count = 0;
	int checked = 0;
	int n_splat = 0;
	int n_read = 0;
	int n_clear = 0;
	int n_other = 0;
	int n_updates = 0;
	int n_settings = 0;
	int clears_left = 3;
	int last_x = 0;
	int last_y = 0;
	int last_z = 0;

	initial begin
		foreach (voxel_counts[i])
			voxel_counts[i] = '0;
	end

	// Advance the volume by one request and return the response it must produce.
	function automatic splat_rsp_t step_volume(splat_req_t r);
		splat_rsp_t res;
		int rx, ry, rz, sx, sy, sz, prod, wx, wy, wz, ell_sum;
		int dx, dy, dz, xo, yo, zo, hits;
		int slot;
		res = '0;
		hits = 0;
		case (r.kind)
			KIND_SPLAT: begin
				n_splat++;
				rx = (int'(rad_x) > MAX_RADIUS) ? MAX_RADIUS : int'(rad_x);
				ry = (int'(rad_y) > MAX_RADIUS) ? MAX_RADIUS : int'(rad_y);
				rz = (int'(rad_z) > MAX_RADIUS) ? MAX_RADIUS : int'(rad_z);
				sx = rx * rx;
				sy = ry * ry;
				sz = rz * rz;
				prod = (sx != 0 ? sx : 1) * (sy != 0 ? sy : 1) * (sz != 0 ? sz : 1);
				wx = sx != 0 ? prod / sx : 0;
				wy = sy != 0 ? prod / sy : 0;
				wz = sz != 0 ? prod / sz : 0;
				for (dz = -rz; dz <= rz; dz++) begin
					for (dy = -ry; dy <= ry; dy++) begin
						for (dx = -rx; dx <= rx; dx++) begin
							ell_sum = dx * dx * wx + dy * dy * wy + dz * dz * wz;
							xo = int'($signed(r.point_x)) + dx - int'(win_x);
							yo = int'($signed(r.point_y)) + dy - int'(win_y);
							zo = int'($signed(r.point_z)) + dz - int'(win_z);
							if (ell_sum <= prod && xo >= 0 && xo < VOL_W && yo >= 0
									&& yo < VOL_H && zo >= 0 && zo < VOL_D) begin
								slot = zo * VOL_W * VOL_H + yo * VOL_W + xo;
								if (voxel_counts[slot] < COUNT_CAP)
									voxel_counts[slot] = voxel_counts[slot] + 1'b1;
								if (voxel_counts[slot] > peak_level)
									peak_level = voxel_counts[slot];
								if (hits < HIT_CAP)
									hits++;
								n_updates++;
							end
						end
					end
				end
			end
			KIND_READ: begin
				n_read++;
				if (int'(r.voxel_index) < VOXELS)
					res.voxel_count = voxel_counts[r.voxel_index][OUT_CNT_W-1:0];
			end
			KIND_CLEAR: begin
				n_clear++;
				foreach (voxel_counts[i])
					voxel_counts[i] = '0;
				peak_level = '0;
			end
			default: n_other++;
		endcase
		res.max_count = peak_level[OUT_CNT_W-1:0];
		res.voxels_hit = hits[HIT_W-1:0];
		return res;
	endfunction

	// Request driver: presents queued requests, with random gaps between them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (req_if.valid && req_if.ready)
				awaited_responses.insert(awaited_responses.size(), step_volume(cur_req));
			if (!req_if.valid || req_if.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_if.valid <= 1'b0;
				end else if (queued_requests.size() > 0) begin
					cur_req = queued_requests.pop_front();
					req_if.valid <= 1'b1;
					req_if.kind <= cur_req.kind;
					req_if.point_x <= cur_req.point_x;
					req_if.point_y <= cur_req.point_y;
					req_if.point_z <= cur_req.point_z;
					req_if.voxel_index <= cur_req.voxel_index;
					if (!calm && $urandom_range(0, 3) == 0)
						gap_left = $urandom_range(1, 12);
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: random stall bursts, compares against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : monitor
		splat_rsp_t want;
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (awaited_responses.size() == 0) begin
					$display("%0t: response with none outstanding: count %0d max %0d hits %0d",
						$time, rsp_if.voxel_count, rsp_if.max_count, rsp_if.voxels_hit);
					fail_count++;
				end else begin
					want = awaited_responses.pop_front();
					if (rsp_if.voxel_count !== want.voxel_count) begin
						$display("%0t: voxel_count expected %0d, got %0d",
							$time, want.voxel_count, rsp_if.voxel_count);
						fail_count++;
					end
					if (rsp_if.max_count !== want.max_count) begin
						$display("%0t: max_count expected %0d, got %0d",
							$time, want.max_count, rsp_if.max_count);
						fail_count++;
					end
					if (rsp_if.voxels_hit !== want.voxels_hit) begin
						$display("%0t: voxels_hit expected %0d, got %0d",
							$time, want.voxels_hit, rsp_if.voxels_hit);
						fail_count++;
					end
					checked++;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_if.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 19) == 0) begin
				stall_left = $urandom_range(0, 11);
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: timeout after %0d cycles, %0d responses outstanding",
			$time, cycle_count, awaited_responses.size());
		$display("FAIL ellipsoid_point_splat_volume");
		$finish;
	end

	function automatic logic signed [POS_W-1:0] fit_pos(int v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return v[POS_W-1:0];
	endfunction

	function automatic int rnd_pos();
		logic [POS_W-1:0] bits;
		bits = POS_W'($urandom);
		return int'($signed(bits));
	endfunction

	function automatic logic [IDX_W-1:0] rnd_index();
		logic [IDX_W-1:0] bits;
		bits = IDX_W'($urandom);
		return bits;
	endfunction

	task automatic queue_request(input logic [KIND_W-1:0] kind, input int px, input int py,
			input int pz, input logic [IDX_W-1:0] idx);
		splat_req_t r;
		r.kind = kind;
		r.point_x = fit_pos(px);
		r.point_y = fit_pos(py);
		r.point_z = fit_pos(pz);
		r.voxel_index = idx;
		queued_requests.insert(queued_requests.size(), r);
	endtask

	// Hold until every queued request was taken and every response came back.
	task automatic settle();
		do
			@(negedge clk);
		while (queued_requests.size() != 0 || req_if.valid || awaited_responses.size() != 0);
	endtask

	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ORIGIN_X: win_x = value[POS_W-1:0];
			REG_ORIGIN_Y: win_y = value[POS_W-1:0];
			REG_ORIGIN_Z: win_z = value[POS_W-1:0];
			REG_RADIUS_X: rad_x = value[RAD_W-1:0];
			REG_RADIUS_Y: rad_y = value[RAD_W-1:0];
			REG_RADIUS_Z: rad_z = value[RAD_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_window(input int ox, input int oy, input int oz,
			input int rx, input int ry, input int rz);
		reg_write(REG_ORIGIN_X, DATA_W'(ox));
		reg_write(REG_ORIGIN_Y, DATA_W'(oy));
		reg_write(REG_ORIGIN_Z, DATA_W'(oz));
		reg_write(REG_RADIUS_X, DATA_W'(rx));
		reg_write(REG_RADIUS_Y, DATA_W'(ry));
		reg_write(REG_RADIUS_Z, DATA_W'(rz));
		n_settings++;
	endtask

	// Mostly splats landing on or near the window, with reads that revisit them.
	task automatic queue_random(input int n_items);
		int i, pick, rel_x, rel_y, rel_z;
		for (i = 0; i < n_items; i++) begin
			if (i == n_items / 2)
				settle();
			pick = $urandom_range(0, 99);
			if (pick < 62) begin
				last_x = int'(win_x) + int'($urandom_range(0, VOL_W + 15)) - 8;
				last_y = int'(win_y) + int'($urandom_range(0, VOL_H + 15)) - 8;
				last_z = int'(win_z) + int'($urandom_range(0, VOL_D + 15)) - 8;
				queue_request(KIND_SPLAT, last_x, last_y, last_z, rnd_index());
			end else if (pick < 70) begin
				queue_request(KIND_SPLAT, rnd_pos(), rnd_pos(), rnd_pos(), rnd_index());
			end else if (pick < 92) begin
				if (pick[0]) begin
					rel_x = last_x - int'(win_x) + int'($urandom_range(0, 2)) - 1;
					rel_y = last_y - int'(win_y) + int'($urandom_range(0, 2)) - 1;
					rel_z = last_z - int'(win_z) + int'($urandom_range(0, 2)) - 1;
					queue_request(KIND_READ, rnd_pos(), rnd_pos(), rnd_pos(),
						{rel_z[COORD_W-1:0], rel_y[COORD_W-1:0], rel_x[COORD_W-1:0]});
				end else begin
					queue_request(KIND_READ, rnd_pos(), rnd_pos(), rnd_pos(), rnd_index());
				end
			end else if (pick < 96 || clears_left == 0) begin
				queue_request(KIND_UNUSED, rnd_pos(), rnd_pos(), rnd_pos(), rnd_index());
			end else begin
				clears_left--;
				queue_request(KIND_CLEAR, rnd_pos(), rnd_pos(), rnd_pos(), rnd_index());
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_if.valid = 1'b0;
		req_if.kind = KIND_SPLAT;
		req_if.point_x = '0;
		req_if.point_y = '0;
		req_if.point_z = '0;
		req_if.voxel_index = '0;
		rsp_if.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: unit sphere at the origin, window corners and far points.
		queue_request(KIND_READ, 0, 0, 0, '0);
		queue_request(KIND_SPLAT, 0, 0, 0, '1);
		queue_request(KIND_SPLAT, 0, 0, 0, '0);
		queue_request(KIND_SPLAT, VOL_W - 1, VOL_H - 1, VOL_D - 1, '0);
		queue_request(KIND_SPLAT, -1, -1, -1, '1);
		queue_request(KIND_SPLAT, 32767, -32768, 32767, '0);
		queue_request(KIND_READ, -1, -1, -1, '0);
		queue_request(KIND_READ, 32767, -32768, 32767, '1);
		queue_request(KIND_READ, 0, 0, 0, IDX_W'(1));
		queue_request(KIND_UNUSED, -32768, 32767, -32768, '1);
		queue_request(KIND_CLEAR, 0, 0, 0, '0);
		queue_request(KIND_READ, 0, 0, 0, '0);
		queue_request(KIND_SPLAT, 5, 0, 0, '0);
		settle();

		// Largest ellipsoid at the most negative window.
		set_window(-32768, -32768, -32768, 7, 7, 7);
		queue_request(KIND_SPLAT, -32768, -32768, -32768, '0);
		queue_request(KIND_SPLAT, -32761, -32761, -32761, '1);
		queue_request(KIND_READ, 0, 0, 0, IDX_W'(7 * VOL_W * VOL_H + 7 * VOL_W + 7));
		settle();

		// Zero radius on every axis at the most positive window.
		set_window(32767, 32767, 32767, 0, 0, 0);
		queue_request(KIND_SPLAT, 32767, 32767, 32767, '1);
		queue_request(KIND_SPLAT, 32766, 32767, 32767, '0);
		queue_request(KIND_READ, 0, 0, 0, '0);
		settle();

		// Mixed radii, one axis flat.
		set_window(0, 0, 0, 0, 3, 7);
		queue_request(KIND_SPLAT, 10, 10, 10, '0);
		queue_request(KIND_SPLAT, 0, 16, VOL_D - 1, '0);
		queue_request(KIND_READ, 0, 0, 0, IDX_W'(10 * VOL_W * VOL_H + 10 * VOL_W + 10));
		settle();

		set_window(int'($urandom_range(0, 80)) - 40, int'($urandom_range(0, 80)) - 40,
			int'($urandom_range(0, 80)) - 40, $urandom_range(0, 7), $urandom_range(0, 7),
			$urandom_range(0, 7));
		queue_random(26);
		settle();

		set_window(rnd_pos(), rnd_pos(), rnd_pos(), $urandom_range(0, 7), $urandom_range(0, 7),
			$urandom_range(0, 7));
		queue_random(26);
		settle();

		set_window(0, 0, 0, 7, 7, 7);
		queue_random(16);
		settle();

		set_window(int'($urandom_range(0, 16)) - 8, int'($urandom_range(0, 16)) - 8,
			int'($urandom_range(0, 16)) - 8, 0, 0, 0);
		queue_random(26);
		settle();

		set_window(32767, -32768, int'($urandom_range(0, 16)) - 8, $urandom_range(0, 7),
			$urandom_range(0, 7), $urandom_range(0, 7));
		queue_random(26);
		settle();

		// Final stretch runs without any idling on either side.
		calm = 1'b1;
		set_window(int'($urandom_range(0, 40)) - 20, int'($urandom_range(0, 40)) - 20,
			int'($urandom_range(0, 40)) - 20, $urandom_range(0, 7), $urandom_range(0, 7),
			$urandom_range(0, 7));
		queue_random(30);
		settle();
		repeat (40) @(posedge clk);

		$display("Covered %0d splats (%0d voxel updates), %0d reads, %0d clears, %0d unused kinds",
			n_splat, n_updates, n_read, n_clear, n_other);
		$display("over %0d register settings; %0d responses checked, %0d mismatches",
			n_settings, checked, fail_count);
		if (fail_count == 0)
			$display("PASS ellipsoid_point_splat_volume");
		else
			$display("FAIL ellipsoid_point_splat_volume");
		$finish;
	end

endmodule
